>>> rtl/drvl_pkg.sv
// ----------------------------------------------------------------------------
// drvl_pkg
// Shared types and constants of the distance-vector route learner.
// ----------------------------------------------------------------------------
package drvl_pkg;

  localparam int ADDR_W      = 48;
  localparam int COORD_W     = 10;
  localparam int RANGE_W     = 11;
  localparam int HOPS_W      = 8;
  localparam int COUNT_OUT_W = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int PROD_W      = 2 * RANGE_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_X        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_Y        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_RANGE = 2'd3;

  localparam logic [HOPS_W-1:0] HOPS_MAX       = '1;
  localparam logic [HOPS_W-1:0] NEIGHBOUR_HOPS = 8'd1;

  // one route table row as held in memory
  typedef struct packed {
    logic [HOPS_W-1:0] hops;
    logic [ADDR_W-1:0] next_hop;
    logic [ADDR_W-1:0] dest;
  } route_t;

  // status from the range unit
  typedef struct packed {
    logic done;
    logic heard;
  } dist_sts_t;

endpackage

>>> rtl/drvl_ram.sv
// ----------------------------------------------------------------------------
// drvl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module drvl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/drvl_dist.sv
// ----------------------------------------------------------------------------
// drvl_dist
// Range test: 0 < dx*dx + dy*dy <= range*range on one shared 11x11 multiplier.
// ----------------------------------------------------------------------------
module drvl_dist (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [drvl_pkg::COORD_W-1:0] sx,
  input  logic [drvl_pkg::COORD_W-1:0] sy,
  input  logic [drvl_pkg::COORD_W-1:0] ox,
  input  logic [drvl_pkg::COORD_W-1:0] oy,
  input  logic [drvl_pkg::RANGE_W-1:0] rng,
  output drvl_pkg::dist_sts_t          sts
);

  localparam logic [1:0] STEP_DX  = 2'd0;
  localparam logic [1:0] STEP_DY  = 2'd1;
  localparam logic [1:0] STEP_RNG = 2'd2;
  localparam logic [1:0] STEP_CMP = 2'd3;

  logic [drvl_pkg::COORD_W-1:0] dx_r, dy_r;
  logic [drvl_pkg::RANGE_W-1:0] rng_r;
  logic [1:0]                   step_r;
  logic                         busy_r;
  logic [drvl_pkg::PROD_W-1:0]  prod_r, acc_r;
  logic [drvl_pkg::RANGE_W-1:0] op;

  always_comb begin
    unique case (step_r)
      STEP_DX:  op = {1'b0, dx_r};
      STEP_DY:  op = {1'b0, dy_r};
      default:  op = rng_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= STEP_DX;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= STEP_DX;
      dx_r   <= (sx > ox) ? sx - ox : ox - sx;
      dy_r   <= (sy > oy) ? sy - oy : oy - sy;
      rng_r  <= rng;
    end else if (busy_r) begin
      prod_r <= op * op;
      unique case (step_r)
        STEP_DX: step_r <= STEP_DY;
        STEP_DY: begin
          acc_r  <= prod_r;
          step_r <= STEP_RNG;
        end
        STEP_RNG: begin
          acc_r  <= acc_r + prod_r;
          step_r <= STEP_CMP;
        end
        default: busy_r <= 1'b0;
      endcase
    end
  end

  // acc holds dist^2, prod holds range^2 in the compare step
  assign sts.done  = busy_r && (step_r == STEP_CMP);
  assign sts.heard = (acc_r != '0) && (acc_r <= prod_r);

endmodule

>>> rtl/distance_vector_route_learner.sv
// ----------------------------------------------------------------------------
// distance_vector_route_learner
// Learns routes from neighbour advertisements into a table walked per item.
// ----------------------------------------------------------------------------
//  channel | ports                              | direction | transfer when
//  --------+------------------------------------+-----------+--------------------
//  in      | in_valid/in_stall + 6 fields       | input     | valid && !stall
//  out     | out_valid/out_stall + 5 fields     | output    | valid && !stall
//  cfg     | cfg_we, cfg_index, cfg_wdata       | input     | cfg_we
//
//  Each item runs the range test in the shared multiplier, then up to two
//  table walks, one entry per cycle through the RAM read port.
//  Reset is synchronous and active low; it empties the table (count only).
//  in_stall is high from the accepting edge until the result is loaded into
//  the output register; a stalled result does not block the next transfer,
//  only the loading of the one after it.
// ----------------------------------------------------------------------------
module distance_vector_route_learner #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic [drvl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [drvl_pkg::ADDR_W-1:0]      cfg_wdata,
  // advertisement input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [drvl_pkg::COORD_W-1:0]     in_sender_x,
  input  logic [drvl_pkg::COORD_W-1:0]     in_sender_y,
  input  logic [drvl_pkg::ADDR_W-1:0]      in_sender_address,
  input  logic                             in_has_entry,
  input  logic [drvl_pkg::ADDR_W-1:0]      in_advertised_destination,
  input  logic [drvl_pkg::HOPS_W-1:0]      in_advertised_hops,
  // result output
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_in_range,
  output logic                             out_neighbour_added,
  output logic                             out_route_added,
  output logic                             out_table_full,
  output logic [drvl_pkg::COUNT_OUT_W-1:0] out_entry_count
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DIST   = 7'b0000010,
    ST_SRCH_S = 7'b0000100,
    ST_ADD_S  = 7'b0001000,
    ST_SRCH_D = 7'b0010000,
    ST_ADD_D  = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  // configuration registers
  logic [drvl_pkg::COORD_W-1:0] own_x_r, own_y_r;
  logic [drvl_pkg::ADDR_W-1:0]  own_address_r;
  logic [drvl_pkg::RANGE_W-1:0] signal_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_x_r        <= '0;
      own_y_r        <= '0;
      own_address_r  <= '0;
      signal_range_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        drvl_pkg::CFG_OWN_X:        own_x_r        <= cfg_wdata[drvl_pkg::COORD_W-1:0];
        drvl_pkg::CFG_OWN_Y:        own_y_r        <= cfg_wdata[drvl_pkg::COORD_W-1:0];
        drvl_pkg::CFG_OWN_ADDRESS:  own_address_r  <= cfg_wdata;
        drvl_pkg::CFG_SIGNAL_RANGE: signal_range_r <= cfg_wdata[drvl_pkg::RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state and item registers
  state_t                       state_r, state_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [CNT_W-1:0]             scan_r, scan_nxt;
  logic                         chk_r, chk_nxt;
  logic [drvl_pkg::ADDR_W-1:0]  sender_r, dest_r;
  logic [drvl_pkg::HOPS_W-1:0]  hops_r;
  logic                         has_entry_r;
  logic                         heard_r, heard_nxt;
  logic                         nb_r, nb_nxt;
  logic                         rt_r, rt_nxt;
  logic                         full_r, full_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_load;
  logic                         out_in_range_r, out_nb_r, out_rt_r, out_full_r;
  logic [drvl_pkg::COUNT_OUT_W-1:0] out_count_r;

  logic                         accept;
  drvl_pkg::dist_sts_t          dist_sts;

  // table memory
  logic                         ram_we;
  logic [IDX_W-1:0]             ram_rd_addr;
  drvl_pkg::route_t             ram_wr_data, ram_rd_data;
  logic [drvl_pkg::ADDR_W-1:0]  key;
  logic                         issue, hit, miss, want_dest, has_room;
  logic [drvl_pkg::HOPS_W-1:0]  hops_inc;

  assign accept = in_valid && !in_stall;

  drvl_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .sx    (in_sender_x),
    .sy    (in_sender_y),
    .ox    (own_x_r),
    .oy    (own_y_r),
    .rng   (signal_range_r),
    .sts   (dist_sts)
  );

  drvl_ram #(
    .WIDTH ($bits(drvl_pkg::route_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // The table walk is pipelined: address issued at scan_r, compared on the
  // registered read data when chk_r is set. Only the first count_r entries are ever read.
  assign key         = (state_r == ST_SRCH_D) ? dest_r : sender_r;
  assign ram_rd_addr = scan_r[IDX_W-1:0];
  assign issue       = scan_r < count_r;
  assign hit         = chk_r && (ram_rd_data.dest == key);
  assign miss        = !hit && !issue && !chk_r;
  assign want_dest   = has_entry_r && (dest_r != own_address_r);
  assign has_room    = count_r < FULL_CNT;
  assign hops_inc    = (hops_r == drvl_pkg::HOPS_MAX) ? drvl_pkg::HOPS_MAX
                                                      : hops_r + 1'b1;
  assign out_load    = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    chk_nxt       = 1'b0;
    heard_nxt     = heard_r;
    nb_nxt        = nb_r;
    rt_nxt        = rt_r;
    full_nxt      = full_r;
    ram_we        = 1'b0;
    ram_wr_data   = '{hops: drvl_pkg::NEIGHBOUR_HOPS, next_hop: sender_r, dest: sender_r};
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          heard_nxt = 1'b0;
          nb_nxt    = 1'b0;
          rt_nxt    = 1'b0;
          full_nxt  = 1'b0;
          state_nxt = ST_DIST;
        end
      end
      ST_DIST: begin
        scan_nxt = '0;
        if (dist_sts.done) begin
          heard_nxt = dist_sts.heard;
          state_nxt = dist_sts.heard ? ST_SRCH_S : ST_DONE;
        end
      end
      ST_SRCH_S, ST_SRCH_D: begin
        chk_nxt = issue;
        if (issue) begin
          scan_nxt = scan_r + 1'b1;
        end
        if (hit || miss) begin
          chk_nxt  = 1'b0;
          scan_nxt = '0;
        end
        if (state_r == ST_SRCH_S) begin
          if (miss) begin
            state_nxt = ST_ADD_S;
          end else if (hit) begin
            state_nxt = want_dest ? ST_SRCH_D : ST_DONE;
          end
        end else begin
          if (miss) begin
            state_nxt = ST_ADD_D;
          end else if (hit) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_ADD_S: begin
        if (has_room) begin
          ram_we    = 1'b1;
          count_nxt = count_r + 1'b1;
          nb_nxt    = 1'b1;
        end else begin
          full_nxt  = 1'b1;
        end
        state_nxt = want_dest ? ST_SRCH_D : ST_DONE;
      end
      ST_ADD_D: begin
        ram_wr_data = '{hops: hops_inc, next_hop: sender_r, dest: dest_r};
        if (has_room) begin
          ram_we    = 1'b1;
          count_nxt = count_r + 1'b1;
          rt_nxt    = 1'b1;
        end else begin
          full_nxt  = 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item and result payload, no reset needed
  always_ff @(posedge clk) begin
    heard_r <= heard_nxt;
    nb_r    <= nb_nxt;
    rt_r    <= rt_nxt;
    full_r  <= full_nxt;
    if (accept) begin
      sender_r    <= in_sender_address;
      dest_r      <= in_advertised_destination;
      hops_r      <= in_advertised_hops;
      has_entry_r <= in_has_entry;
    end
    if (out_load) begin
      out_in_range_r <= heard_r;
      out_nb_r       <= nb_r;
      out_rt_r       <= rt_r;
      out_full_r     <= full_r;
      out_count_r    <= drvl_pkg::COUNT_OUT_W'(count_r);
    end
  end

  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_in_range        = out_in_range_r;
  assign out_neighbour_added = out_nb_r;
  assign out_route_added     = out_rt_r;
  assign out_table_full      = out_full_r;
  assign out_entry_count     = out_count_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("route count beyond table size");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> has_room)
    else $error("table write with no free entry");

  a_write_count: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> count_r == $past(count_r) + 1'b1)
    else $error("count did not follow table write");

  a_unheard_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_in_range_r) |-> (!out_nb_r && !out_rt_r && !out_full_r))
    else $error("flags set for a sender out of range");

  a_flag_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> !(nb_r && rt_r && full_r))
    else $error("added both routes yet reported full");

endmodule
